@@ src/vfcao_pkg.sv @@
// Shared types, constants and a helper function for the voxel face culling block.
package vfcao_pkg;

    localparam int EDGE_LENGTH = 32;
    localparam int POS_W       = $clog2(EDGE_LENGTH);
    localparam int MAT_W       = 8;
    localparam int NB_W        = 27;
    localparam int NB_IDX_W    = $clog2(NB_W);
    localparam int FACE_COUNT  = 6;
    localparam int FACE_W      = $clog2(FACE_COUNT);
    localparam int CORNERS     = 4;
    localparam int AO_W        = 2;

    localparam logic [NB_IDX_W-1:0] CENTRE_BIT = NB_IDX_W'(13);

    // Neighbourhood bit of the cell across each face (+X,-X,+Y,-Y,+Z,-Z)
    localparam logic [NB_IDX_W-1:0] FACE_NB [FACE_COUNT] = '{
        5'd14, 5'd12, 5'd16, 5'd10, 5'd22, 5'd4
    };

    // Per face and corner: side one, side two, diagonal corner
    localparam logic [NB_IDX_W-1:0] CORNER_NB [FACE_COUNT][CORNERS][3] = '{
        '{ '{5'd5,  5'd11, 5'd2},  '{5'd5,  5'd17, 5'd8},
           '{5'd23, 5'd17, 5'd26}, '{5'd23, 5'd11, 5'd20} },
        '{ '{5'd3,  5'd15, 5'd6},  '{5'd3,  5'd9,  5'd0},
           '{5'd21, 5'd9,  5'd18}, '{5'd21, 5'd15, 5'd24} },
        '{ '{5'd7,  5'd17, 5'd8},  '{5'd7,  5'd15, 5'd6},
           '{5'd25, 5'd15, 5'd24}, '{5'd25, 5'd17, 5'd26} },
        '{ '{5'd1,  5'd9,  5'd0},  '{5'd1,  5'd11, 5'd2},
           '{5'd19, 5'd11, 5'd20}, '{5'd19, 5'd9,  5'd18} },
        '{ '{5'd21, 5'd19, 5'd18}, '{5'd23, 5'd19, 5'd20},
           '{5'd23, 5'd25, 5'd26}, '{5'd21, 5'd25, 5'd24} },
        '{ '{5'd3,  5'd7,  5'd6},  '{5'd5,  5'd7,  5'd8},
           '{5'd5,  5'd1,  5'd2},  '{5'd3,  5'd1,  5'd0} }
    };

    typedef struct packed {
        logic [POS_W-1:0] pos_x;
        logic [POS_W-1:0] pos_y;
        logic [POS_W-1:0] pos_z;
        logic [MAT_W-1:0] material;
        logic [NB_W-1:0]  neighbourhood;
    } voxel_t;

    typedef struct packed {
        logic [POS_W-1:0]  out_x;
        logic [POS_W-1:0]  out_y;
        logic [POS_W-1:0]  out_z;
        logic [MAT_W-1:0]  out_material;
        logic [FACE_W-1:0] face;
        logic [AO_W-1:0]   occlusion_v0;
        logic [AO_W-1:0]   occlusion_v1;
        logic [AO_W-1:0]   occlusion_v2;
        logic [AO_W-1:0]   occlusion_v3;
        logic              split_flip;
        logic              last_face;
    } quad_t;

    // Decode stage: voxel plus its visible face mask
    typedef struct packed {
        logic [POS_W-1:0]      pos_x;
        logic [POS_W-1:0]      pos_y;
        logic [POS_W-1:0]      pos_z;
        logic [MAT_W-1:0]      material;
        logic [NB_W-1:0]       neighbourhood;
        logic [FACE_COUNT-1:0] mask;
    } dec_t;

    // Shade stage: corner levels and diagonal choice of every face
    typedef struct packed {
        logic [POS_W-1:0]                          pos_x;
        logic [POS_W-1:0]                          pos_y;
        logic [POS_W-1:0]                          pos_z;
        logic [MAT_W-1:0]                          material;
        logic [FACE_COUNT-1:0]                     mask;
        logic [FACE_COUNT-1:0][CORNERS-1:0][AO_W-1:0] ao;
        logic [FACE_COUNT-1:0]                     flip;
    } shade_t;

    // Corner level: dark when both sides are solid, else 3 minus solid count
    function automatic logic [AO_W-1:0] corner_level(input logic s1, input logic s2,
                                                     input logic cr);
        logic [AO_W-1:0] cnt;
        cnt = AO_W'(s1) + AO_W'(s2) + AO_W'(cr);
        if (s1 && s2)
            return '0;
        return AO_W'(3) - cnt;
    endfunction

endpackage

@@ src/vfcao_decode.sv @@
// Decode stage: register the voxel and find its visible faces.
module vfcao_decode
    import vfcao_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   voxel_valid,
    output logic   voxel_stall,
    input  voxel_t voxel,
    output logic   dec_valid,
    input  logic   dec_stall,
    output dec_t   dec
);

    logic                  valid_reg;
    logic                  valid_next;
    dec_t                  data_reg;
    dec_t                  data_next;
    logic [FACE_COUNT-1:0] mask;
    logic                  hold;

    // Face is visible when the voxel is solid and the cell across is empty
    always_comb
    begin
        for (int f = 0; f < FACE_COUNT; f++)
        begin
            mask[f] = voxel.neighbourhood[CENTRE_BIT] & ~voxel.neighbourhood[FACE_NB[f]];
        end
    end

    assign hold        = valid_reg && dec_stall;
    assign voxel_stall = hold;

    // Drop voxels that show no face
    always_comb
    begin
        valid_next              = voxel_valid && (mask != '0);
        data_next.pos_x         = voxel.pos_x;
        data_next.pos_y         = voxel.pos_y;
        data_next.pos_z         = voxel.pos_z;
        data_next.material      = voxel.material;
        data_next.neighbourhood = voxel.neighbourhood;
        data_next.mask          = mask;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (!hold)
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (!hold)
            data_reg <= data_next;
    end

    assign dec_valid = valid_reg;
    assign dec       = data_reg;

endmodule

@@ src/vfcao_shade.sv @@
// Shade stage: compute corner occlusion levels and split choice for all faces.
module vfcao_shade
    import vfcao_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   dec_valid,
    output logic   dec_stall,
    input  dec_t   dec,
    output logic   shade_valid,
    input  logic   shade_stall,
    output shade_t shade
);

    logic   valid_reg;
    shade_t data_reg;
    shade_t data_next;
    logic   hold;

    assign hold      = valid_reg && shade_stall;
    assign dec_stall = hold;

    // Evaluate every corner of every face in parallel
    always_comb
    begin
        data_next.pos_x    = dec.pos_x;
        data_next.pos_y    = dec.pos_y;
        data_next.pos_z    = dec.pos_z;
        data_next.material = dec.material;
        data_next.mask     = dec.mask;
        for (int f = 0; f < FACE_COUNT; f++)
        begin
            for (int v = 0; v < CORNERS; v++)
            begin
                data_next.ao[f][v] = corner_level(dec.neighbourhood[CORNER_NB[f][v][0]],
                                                  dec.neighbourhood[CORNER_NB[f][v][1]],
                                                  dec.neighbourhood[CORNER_NB[f][v][2]]);
            end
            data_next.flip[f] =
                ({1'b0, data_next.ao[f][0]} + {1'b0, data_next.ao[f][2]}) >
                ({1'b0, data_next.ao[f][1]} + {1'b0, data_next.ao[f][3]});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (!hold)
            valid_reg <= dec_valid;
    end

    always_ff @(posedge clk)
    begin
        if (!hold)
            data_reg <= data_next;
    end

    assign shade_valid = valid_reg;
    assign shade       = data_reg;

endmodule

@@ src/vfcao_serial.sv @@
// Face serializer: hold one voxel and issue its visible faces one per cycle while the output is not stalled.
module vfcao_serial
    import vfcao_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   shade_valid,
    output logic   shade_stall,
    input  shade_t shade,
    output logic   q_valid,
    input  logic   q_stall,
    output quad_t  q
);

    logic                  busy_reg;
    shade_t                cur_reg;
    logic [FACE_COUNT-1:0] rem_reg;
    logic [FACE_COUNT-1:0] rem_next;
    logic [FACE_COUNT-1:0] pick;
    logic [FACE_COUNT-1:0] rest;
    logic [FACE_W-1:0]     sel;
    logic                  last_now;
    logic                  emit;
    logic                  load;

    // Pick the lowest remaining face
    always_comb
    begin
        sel = '0;
        for (int f = FACE_COUNT - 1; f >= 0; f--)
        begin
            if (rem_reg[f])
                sel = FACE_W'(f);
        end
        pick     = FACE_COUNT'(1) << sel;
        rest     = rem_reg & ~pick;
        last_now = (rest == '0);
    end

    assign emit        = busy_reg && !q_stall;
    assign shade_stall = busy_reg && !(emit && last_now);
    assign load        = !shade_stall;

    // Advance to the next face, or load the next voxel after the last one
    always_comb
    begin
        rem_next = rem_reg;
        if (load)
            rem_next = shade.mask;
        else if (emit)
            rem_next = rest;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            rem_reg  <= '0;
        end
        else
        begin
            if (load)
                busy_reg <= shade_valid;
            rem_reg <= rem_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            cur_reg <= shade;
    end

    // Build the face transaction
    always_comb
    begin
        q.out_x        = cur_reg.pos_x;
        q.out_y        = cur_reg.pos_y;
        q.out_z        = cur_reg.pos_z;
        q.out_material = cur_reg.material;
        q.face         = sel;
        q.occlusion_v0 = cur_reg.ao[sel][0];
        q.occlusion_v1 = cur_reg.ao[sel][1];
        q.occlusion_v2 = cur_reg.ao[sel][2];
        q.occlusion_v3 = cur_reg.ao[sel][3];
        q.split_flip   = cur_reg.flip[sel];
        q.last_face    = last_now;
    end

    assign q_valid = busy_reg;

`ifndef SYNTH
    a_busy_has_face: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && rem_reg == '0) |-> 1'b0)
        else $error("serializer busy with no face left");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && q_stall) |=> ($stable(rem_reg) && busy_reg))
        else $error("face mask changed while output stalled");

    a_pick_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> ($onehot(pick) && ((pick & rem_reg) != '0)))
        else $error("picked face is not a single remaining face");
`endif

endmodule

@@ src/voxel_face_cull_ambient_occlusion.sv @@
// Top level: voxel face culling with per-corner ambient occlusion, face output register.
// An accepted voxel passes the decode, shade, serializer and output registers in that order.
// Throughput: one face per clock on the one output port while the consumer does not stall.
// A voxel that shows no face (empty or enclosed) is dropped in the decode stage.
// Reset (rst_n low, asynchronous) clears all valid bits and the remaining-face mask; data registers are not reset.
module voxel_face_cull_ambient_occlusion
    import vfcao_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   voxel_valid,
    output logic   voxel_stall,
    input  voxel_t voxel,
    output logic   quad_valid,
    input  logic   quad_stall,
    output quad_t  quad
);

    logic   dec_valid;
    logic   dec_stall;
    dec_t   dec;
    logic   shade_valid;
    logic   shade_stall;
    shade_t shade;
    logic   q_valid;
    logic   q_stall;
    quad_t  q;
    logic   out_valid_reg;
    quad_t  out_reg;

    vfcao_decode u_decode (
        .clk         (clk),
        .rst_n       (rst_n),
        .voxel_valid (voxel_valid),
        .voxel_stall (voxel_stall),
        .voxel       (voxel),
        .dec_valid   (dec_valid),
        .dec_stall   (dec_stall),
        .dec         (dec)
    );

    vfcao_shade u_shade (
        .clk         (clk),
        .rst_n       (rst_n),
        .dec_valid   (dec_valid),
        .dec_stall   (dec_stall),
        .dec         (dec),
        .shade_valid (shade_valid),
        .shade_stall (shade_stall),
        .shade       (shade)
    );

    vfcao_serial u_serial (
        .clk         (clk),
        .rst_n       (rst_n),
        .shade_valid (shade_valid),
        .shade_stall (shade_stall),
        .shade       (shade),
        .q_valid     (q_valid),
        .q_stall     (q_stall),
        .q           (q)
    );

    // Hold the output transaction while the consumer stalls
    assign q_stall = out_valid_reg && quad_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (!q_stall)
            out_valid_reg <= q_valid;
    end

    always_ff @(posedge clk)
    begin
        if (!q_stall)
            out_reg <= q;
    end

    assign quad_valid = out_valid_reg;
    assign quad       = out_reg;

`ifndef SYNTH
    a_face_range: assert property (@(posedge clk) disable iff (!rst_n)
        quad_valid |-> (quad.face < FACE_W'(FACE_COUNT)))
        else $error("face code out of range");

    a_valid_held: assert property (@(posedge clk) disable iff (!rst_n)
        (quad_valid && quad_stall) |=> quad_valid)
        else $error("output valid dropped while stalled");

    a_payload_held: assert property (@(posedge clk) disable iff (!rst_n)
        (quad_valid && quad_stall) |=> $stable(quad))
        else $error("output payload changed while stalled");
`endif

endmodule
